// ----- sv/ordered_event_list_macros.svh -----
// Assertion macros used by the ordered event list checker.
`ifndef ORDERED_EVENT_LIST_MACROS_SVH
`define ORDERED_EVENT_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OEL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered event list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OEL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered event list check failed");

`endif

// ----- sv/oel_pkg.sv -----
// Types, codes and constants of the ordered event list.
`timescale 1ns / 1ps
package oel_pkg;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned OCC_W      = 5;

  localparam logic [3:0] CMD_INS_FRONT  = 4'd0;
  localparam logic [3:0] CMD_INS_REAR   = 4'd1;
  localparam logic [3:0] CMD_INS_TIME   = 4'd2;
  localparam logic [3:0] CMD_INS_BEHIND = 4'd3;
  localparam logic [3:0] CMD_INS_AHEAD  = 4'd4;
  localparam logic [3:0] CMD_POP_FRONT  = 4'd5;
  localparam logic [3:0] CMD_REM_TOKEN  = 4'd6;
  localparam logic [3:0] CMD_REM_EVENT  = 4'd7;
  localparam logic [3:0] CMD_SELECTIVE  = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  typedef struct packed {
    logic [31:0] time_v;
    logic [7:0]  prio;
    logic [15:0] token;
    logic [15:0] evt;
  } entry_t;

  typedef struct packed {
    logic [31:0] time_v;
    logic [7:0]  prio;
    logic [15:0] match;
  } key_t;

  typedef struct packed {
    logic time_gt;
    logic prio_ge;
    logic prio_gt;
    logic tok_eq;
    logic evt_eq;
  } cell_flags_t;

endpackage

// ----- sv/oel_cell.sv -----
// One slot of the event chain: holds an entry, compares it, and shifts.
`timescale 1ns / 1ps
module oel_cell (
  input  logic                 clk_i,
  input  oel_pkg::cell_op_e    op_i,
  input  oel_pkg::entry_t      left_i,
  input  oel_pkg::entry_t      right_i,
  input  oel_pkg::entry_t      new_i,
  input  oel_pkg::key_t        key_i,
  output oel_pkg::entry_t      entry_o,
  output oel_pkg::cell_flags_t flags_o
);

  oel_pkg::entry_t entry_q, entry_d;

  always_comb begin
    unique case (op_i)
      oel_pkg::CELL_HOLD:       entry_d = entry_q;
      oel_pkg::CELL_LOAD:       entry_d = new_i;
      oel_pkg::CELL_FROM_LEFT:  entry_d = left_i;
      oel_pkg::CELL_FROM_RIGHT: entry_d = right_i;
      default:                  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o         = entry_q;
  assign flags_o.time_gt = entry_q.time_v > key_i.time_v;
  assign flags_o.prio_ge = entry_q.prio >= key_i.prio;
  assign flags_o.prio_gt = entry_q.prio > key_i.prio;
  assign flags_o.tok_eq  = entry_q.token == key_i.match;
  assign flags_o.evt_eq  = entry_q.evt == key_i.match;

endmodule

// ----- sv/ordered_event_list.sv -----
// Top level of the ordered event list: command control over a chain of slot cells.
`timescale 1ns / 1ps
// Bounded ordered event list of LIST_DEPTH slots, each a cell that compares its entry with
// the command's key and shifts to either neighbor. A word is taken in S_IDLE, S_DECIDE
// finds the position from all cells at once, and S_APPLY shifts the chain and loads the
// result register once that register is free or being read. Selective removal adds a scan
// over min(scan_limit, occupancy) front slots, one slot a cycle through a shared read
// port, and S_SCAN then closes the scan. A new word is taken only once the previous one
// has been executed; a result may still wait in the output register at that time.
module ordered_event_list #(
  parameter int unsigned LIST_DEPTH = oel_pkg::LIST_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         command_i,
  input  logic [31:0]        entry_time_i,
  input  logic [7:0]         entry_priority_i,
  input  logic [15:0]        entry_token_i,
  input  logic signed [15:0] entry_event_i,
  input  logic signed [15:0] match_id_i,
  input  logic [7:0]         start_class_i,
  input  logic [4:0]         scan_limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        out_time_o,
  output logic [7:0]         out_priority_o,
  output logic [15:0]        out_token_o,
  output logic signed [15:0] out_event_o,
  output logic [4:0]         occupancy_o,
  output logic [4:0]         peak_occupancy_o
);

  localparam int unsigned IDXW = $clog2(LIST_DEPTH);
  localparam int unsigned CNTW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SW   = (CNTW > oel_pkg::OCC_W) ? CNTW : oel_pkg::OCC_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_APPLY  = 2'd3;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] act_q, act_d;
  logic [1:0] stat_q, stat_d;
  logic [IDXW-1:0] pos_q, pos_d;
  logic [CNTW-1:0] count_q, count_d, peak_q, peak_d;
  logic [CNTW-1:0] k_q, k_d;
  logic [SW-1:0]   span;
  logic            found_q, found_d;
  logic [7:0]      best_q, best_d;

  logic [3:0]      cmd_q;
  oel_pkg::entry_t new_q;
  oel_pkg::key_t   key_q;
  logic [7:0]      class_q;
  logic [4:0]      limit_q;

  oel_pkg::entry_t      cell_entry [LIST_DEPTH];
  oel_pkg::cell_flags_t cell_flags [LIST_DEPTH];
  oel_pkg::cell_op_e    cell_op    [LIST_DEPTH];

  logic [LIST_DEPTH-1:0] stop_time, stop_behind, stop_ahead, hit_tok, hit_evt;
  logic [IDXW-1:0] pos_time, pos_behind, pos_ahead, pos_tok, pos_evt;
  logic            any_tok, any_evt;

  logic [IDXW-1:0] rd_idx;
  oel_pkg::entry_t rd_entry;
  logic            eligible, finish;

  logic            out_valid_q;
  logic [1:0]      out_status_q;
  oel_pkg::entry_t out_entry_q;
  logic [4:0]      out_occ_q, out_peak_q;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    oel_pkg::entry_t left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = new_q;
    end else begin : g_mid
      assign left_e = cell_entry[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_e = cell_entry[g];
    end else begin : g_inner
      assign right_e = cell_entry[g+1];
    end
    oel_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .left_i  (left_e),
      .right_i (right_e),
      .new_i   (new_q),
      .key_i   (key_q),
      .entry_o (cell_entry[g]),
      .flags_o (cell_flags[g])
    );
    logic live;
    assign live           = CNTW'(g) < count_q;
    assign stop_time[g]   = !live || cell_flags[g].time_gt;
    assign stop_behind[g] = !live || !cell_flags[g].prio_ge;
    assign stop_ahead[g]  = !live || !cell_flags[g].prio_gt;
    assign hit_tok[g]     = live && cell_flags[g].tok_eq;
    assign hit_evt[g]     = live && cell_flags[g].evt_eq;
  end

  // First set flag of each vector; the descending loop leaves the lowest index.
  always_comb begin
    pos_time   = '0;
    pos_behind = '0;
    pos_ahead  = '0;
    pos_tok    = '0;
    pos_evt    = '0;
    any_tok    = 1'b0;
    any_evt    = 1'b0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (stop_time[i])   pos_time   = IDXW'(i);
      if (stop_behind[i]) pos_behind = IDXW'(i);
      if (stop_ahead[i])  pos_ahead  = IDXW'(i);
      if (hit_tok[i]) begin
        pos_tok = IDXW'(i);
        any_tok = 1'b1;
      end
      if (hit_evt[i]) begin
        pos_evt = IDXW'(i);
        any_evt = 1'b1;
      end
    end
  end

  assign rd_idx   = (state_q == S_SCAN) ? k_q[IDXW-1:0] : pos_q;
  assign rd_entry = cell_entry[rd_idx];

  always_comb begin
    if (SW'(limit_q) < SW'(count_q)) span = SW'(limit_q);
    else                             span = SW'(count_q);
  end

  // A lower class only wins if no higher class within the start class has been seen.
  always_comb begin
    if (class_q == 8'd0) eligible = rd_entry.prio == 8'd0;
    else eligible = (rd_entry.prio != 8'd0) && (rd_entry.prio <= class_q);
  end

  assign finish = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    stat_d  = stat_q;
    pos_d   = pos_q;
    k_d     = k_q;
    found_d = found_q;
    best_d  = best_q;
    count_d = count_q;
    peak_d  = peak_q;
    for (int i = 0; i < LIST_DEPTH; i++) cell_op[i] = oel_pkg::CELL_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        act_d   = ACT_NONE;
        stat_d  = oel_pkg::ST_OK;
        pos_d   = '0;
        state_d = S_APPLY;
        if (cmd_q <= oel_pkg::CMD_INS_AHEAD) begin
          if (count_q >= CNTW'(LIST_DEPTH)) begin
            stat_d = oel_pkg::ST_FULL;
          end else begin
            act_d = ACT_INSERT;
            priority case (cmd_q)
              oel_pkg::CMD_INS_REAR:   pos_d = count_q[IDXW-1:0];
              oel_pkg::CMD_INS_TIME:   pos_d = pos_time;
              oel_pkg::CMD_INS_BEHIND: pos_d = pos_behind;
              oel_pkg::CMD_INS_AHEAD:  pos_d = pos_ahead;
              default:                 pos_d = '0;
            endcase
          end
        end else if (cmd_q <= oel_pkg::CMD_SELECTIVE) begin
          if (count_q == '0) begin
            stat_d = oel_pkg::ST_EMPTY;
          end else begin
            priority case (cmd_q)
              oel_pkg::CMD_POP_FRONT: act_d = ACT_REMOVE;
              oel_pkg::CMD_REM_TOKEN: begin
                if (any_tok) begin
                  act_d = ACT_REMOVE;
                  pos_d = pos_tok;
                end else begin
                  stat_d = oel_pkg::ST_NO_MATCH;
                end
              end
              oel_pkg::CMD_REM_EVENT: begin
                if (any_evt) begin
                  act_d = ACT_REMOVE;
                  pos_d = pos_evt;
                end else begin
                  stat_d = oel_pkg::ST_NO_MATCH;
                end
              end
              default: begin
                act_d   = ACT_REMOVE;
                k_d     = '0;
                found_d = 1'b0;
                best_d  = '0;
                state_d = S_SCAN;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (SW'(k_q) < span) begin
          if (eligible && (!found_q || rd_entry.prio > best_q)) begin
            found_d = 1'b1;
            best_d  = rd_entry.prio;
            pos_d   = k_q[IDXW-1:0];
          end
          k_d = k_q + CNTW'(1);
        end else begin
          if (!found_q) pos_d = '0;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (finish) begin
          state_d = S_IDLE;
          if (act_q == ACT_INSERT) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
              if (IDXW'(i) == pos_q)     cell_op[i] = oel_pkg::CELL_LOAD;
              else if (IDXW'(i) > pos_q) cell_op[i] = oel_pkg::CELL_FROM_LEFT;
            end
            count_d = count_q + CNTW'(1);
            if (count_d > peak_q) peak_d = count_d;
          end else if (act_q == ACT_REMOVE) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
              if (IDXW'(i) >= pos_q) cell_op[i] = oel_pkg::CELL_FROM_RIGHT;
            end
            count_d = count_q - CNTW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
      act_q       <= ACT_NONE;
      stat_q      <= oel_pkg::ST_OK;
      pos_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      act_q   <= act_d;
      stat_q  <= stat_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      found_q <= found_d;
      best_q  <= best_d;
      if (state_q == S_APPLY && finish) out_valid_q <= 1'b1;
      else if (out_ready_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q        <= command_i;
      new_q.time_v <= entry_time_i;
      new_q.prio   <= entry_priority_i;
      new_q.token  <= entry_token_i;
      new_q.evt    <= entry_event_i;
      key_q.time_v <= entry_time_i;
      key_q.prio   <= entry_priority_i;
      key_q.match  <= match_id_i;
      class_q      <= start_class_i;
      limit_q      <= scan_limit_i;
    end
    if (state_q == S_APPLY && finish) begin
      out_status_q <= stat_q;
      if (act_q == ACT_REMOVE) begin
        out_entry_q <= rd_entry;
      end else begin
        out_entry_q.time_v <= '0;
        out_entry_q.prio   <= '0;
        out_entry_q.token  <= '0;
        out_entry_q.evt    <= 16'hFFFF;
      end
      out_occ_q  <= count_d[oel_pkg::OCC_W-1:0];
      out_peak_q <= peak_d[oel_pkg::OCC_W-1:0];
    end
  end

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_time_o       = out_entry_q.time_v;
  assign out_priority_o   = out_entry_q.prio;
  assign out_token_o      = out_entry_q.token;
  assign out_event_o      = out_entry_q.evt;
  assign occupancy_o      = out_occ_q;
  assign peak_occupancy_o = out_peak_q;

endmodule

// ----- sv/oel_checker.sv -----
// Port-level checks of the ordered event list and their bind to the top level.
`timescale 1ns / 1ps
`include "ordered_event_list_macros.svh"
module oel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [15:0] out_event_o,
  input logic [4:0]  occupancy_o,
  input logic [4:0]  peak_occupancy_o
);

  // A failed command never reports a removed entry.
  `OEL_ASSERT_IMP(a_fail_no_entry, clk_i, rst_ni, out_valid_o && status_o != oel_pkg::ST_OK, out_event_o == 16'hFFFF)

  // An empty-list report means nothing is held.
  `OEL_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, out_valid_o && status_o == oel_pkg::ST_EMPTY, occupancy_o == 5'd0)

  // The peak never falls below the current fill.
  `OEL_ASSERT_IMP(a_peak_bound, clk_i, rst_ni, out_valid_o, peak_occupancy_o >= occupancy_o)

  // A result word waits until it is taken.
  `OEL_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

endmodule

bind ordered_event_list oel_checker u_oel_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .out_event_o      (out_event_o),
  .occupancy_o      (occupancy_o),
  .peak_occupancy_o (peak_occupancy_o)
);

// ----- tb/ordered_event_list_tb.sv -----
// Self-checking testbench of the ordered event list: directed and random commands.
`timescale 1ns / 1ps
module ordered_event_list_tb;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] etime;
    logic [7:0]  eprio;
    logic [15:0] etok;
    logic [15:0] eevt;
    logic [15:0] mid;
    logic [7:0]  sclass;
    logic [4:0]  limit;
  } cmd_word_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] rtime;
    logic [7:0]  rprio;
    logic [15:0] rtok;
    logic [15:0] revt;
    logic [4:0]  occ;
    logic [4:0]  peak;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] command_i = '0;
  logic [31:0] entry_time_i = '0;
  logic [7:0] entry_priority_i = '0;
  logic [15:0] entry_token_i = '0;
  logic signed [15:0] entry_event_i = '0;
  logic signed [15:0] match_id_i = '0;
  logic [7:0] start_class_i = '0;
  logic [4:0] scan_limit_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [31:0] out_time_o;
  logic [7:0] out_priority_o;
  logic [15:0] out_token_o;
  logic signed [15:0] out_event_o;
  logic [4:0] occupancy_o;
  logic [4:0] peak_occupancy_o;

  ordered_event_list DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the list as the block should hold it.
  logic [31:0] list_time[oel_pkg::LIST_DEPTH];
  logic [7:0]  list_prio[oel_pkg::LIST_DEPTH];
  logic [15:0] list_tok[oel_pkg::LIST_DEPTH];
  logic [15:0] list_evt[oel_pkg::LIST_DEPTH];
  int unsigned list_count = 0;
  int unsigned list_peak = 0;

  result_word_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int words_sent = 0;
  int hold_off = 0;
  bit gaps_on = 1'b1;

  function automatic result_word_t predict_command(cmd_word_t w);
    result_word_t r;
    int unsigned pos;
    int unsigned span;
    int unsigned cls;
    bit removed;
    bit found;
    pos = 0;
    removed = 0;
    found = 0;
    r.status = oel_pkg::ST_OK;
    r.rtime = '0;
    r.rprio = '0;
    r.rtok = '0;
    r.revt = 16'hFFFF;
    if (w.cmd <= oel_pkg::CMD_INS_AHEAD) begin
      if (list_count >= oel_pkg::LIST_DEPTH) begin
        r.status = oel_pkg::ST_FULL;
      end else begin
        case (w.cmd)
          oel_pkg::CMD_INS_REAR: pos = list_count;
          oel_pkg::CMD_INS_TIME:
            while (pos < list_count && list_time[pos] <= w.etime) pos++;
          oel_pkg::CMD_INS_BEHIND:
            while (pos < list_count && list_prio[pos] >= w.eprio) pos++;
          oel_pkg::CMD_INS_AHEAD:
            while (pos < list_count && list_prio[pos] > w.eprio) pos++;
          default: pos = 0;
        endcase
        for (int k = list_count; k > pos; k--) begin
          list_time[k] = list_time[k-1];
          list_prio[k] = list_prio[k-1];
          list_tok[k] = list_tok[k-1];
          list_evt[k] = list_evt[k-1];
        end
        list_time[pos] = w.etime;
        list_prio[pos] = w.eprio;
        list_tok[pos] = w.etok;
        list_evt[pos] = w.eevt;
        list_count++;
        if (list_count > list_peak) list_peak = list_count;
      end
    end else if (w.cmd <= oel_pkg::CMD_SELECTIVE) begin
      if (list_count == 0) begin
        r.status = oel_pkg::ST_EMPTY;
      end else if (w.cmd == oel_pkg::CMD_POP_FRONT) begin
        removed = 1;
      end else if (w.cmd == oel_pkg::CMD_REM_TOKEN || w.cmd == oel_pkg::CMD_REM_EVENT) begin
        while (pos < list_count &&
               ((w.cmd == oel_pkg::CMD_REM_TOKEN) ? list_tok[pos] : list_evt[pos]) != w.mid)
          pos++;
        if (pos < list_count) removed = 1;
        else r.status = oel_pkg::ST_NO_MATCH;
      end else begin
        cls = w.sclass;
        span = (w.limit < list_count) ? w.limit : list_count;
        forever begin
          for (int k = 0; k < span; k++) begin
            if (list_prio[k] == cls) begin
              pos = k;
              found = 1;
              break;
            end
          end
          if (found || cls <= 1) break;
          cls--;
        end
        if (!found) pos = 0;
        removed = 1;
      end
    end
    if (removed) begin
      r.rtime = list_time[pos];
      r.rprio = list_prio[pos];
      r.rtok = list_tok[pos];
      r.revt = list_evt[pos];
      for (int k = pos; k + 1 < list_count; k++) begin
        list_time[k] = list_time[k+1];
        list_prio[k] = list_prio[k+1];
        list_tok[k] = list_tok[k+1];
        list_evt[k] = list_evt[k+1];
      end
      list_count--;
    end
    r.occ = list_count;
    r.peak = list_peak;
    return r;
  endfunction

  // Offers one word and holds it until accepted; the expectation is queued at acceptance.
  task automatic send_word(cmd_word_t w);
    command_i <= w.cmd;
    entry_time_i <= w.etime;
    entry_priority_i <= w.eprio;
    entry_token_i <= w.etok;
    entry_event_i <= w.eevt;
    match_id_i <= w.mid;
    start_class_i <= w.sclass;
    scan_limit_i <= w.limit;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_command(w));
    words_sent++;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  function automatic cmd_word_t random_word(logic [3:0] cmd);
    cmd_word_t w;
    w.cmd = cmd;
    w.etime = ($urandom_range(0, 1)) ? $urandom() : $urandom_range(0, 40);
    w.eprio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
    w.etok = ($urandom_range(0, 3) == 0) ? $urandom() :
             $urandom_range(0, 7) | 16'h8000 * $urandom_range(0, 1);
    w.eevt = ($urandom_range(0, 3) == 0) ? $urandom() :
             $urandom_range(0, 7) | 16'h8000 * $urandom_range(0, 1);
    w.mid = ($urandom_range(0, 3) == 0) ? $urandom() :
            $urandom_range(0, 7) | 16'h8000 * $urandom_range(0, 1);
    w.sclass = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
    w.limit = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    return w;
  endfunction

  // Result checker: compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    result_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, status_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if ({status_o, out_time_o, out_priority_o, out_token_o, out_event_o, occupancy_o,
             peak_occupancy_o} !== {e.status, e.rtime, e.rprio, e.rtok, e.revt, e.occ,
             e.peak}) begin
          $display("%0t: expected st=%0d t=%h p=%h k=%h e=%h occ=%0d peak=%0d", $time,
                   e.status, e.rtime, e.rprio, e.rtok, e.revt, e.occ, e.peak);
          $display("%0t: actual   st=%0d t=%h p=%h k=%h e=%h occ=%0d peak=%0d", $time,
                   status_o, out_time_o, out_priority_o, out_token_o, out_event_o,
                   occupancy_o, peak_occupancy_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic test_directed();
    cmd_word_t w;
    w = random_word(oel_pkg::CMD_POP_FRONT);
    send_word(w);
    w.cmd = oel_pkg::CMD_REM_TOKEN;
    send_word(w);
    w.cmd = oel_pkg::CMD_SELECTIVE;
    send_word(w);
    w = '{oel_pkg::CMD_INS_REAR, 32'hFFFFFFFF, 8'hFF, 16'hFFFF, 16'h8000, 16'h0, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_INS_FRONT, 32'h0, 8'h0, 16'h0, 16'h7FFF, 16'h0, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_INS_TIME, 32'h100, 8'd3, 16'h8001, 16'd5, 16'h0, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_INS_BEHIND, 32'h50, 8'd3, 16'd2, 16'd6, 16'h0, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_INS_AHEAD, 32'h60, 8'd3, 16'd3, 16'd7, 16'h0, 8'h0, 5'd0};
    send_word(w);
    // Token above 32767 matches the negative id with the same bits.
    w = '{oel_pkg::CMD_REM_TOKEN, 32'h0, 8'h0, 16'h0, 16'h0, 16'h8001, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_REM_EVENT, 32'h0, 8'h0, 16'h0, 16'h0, 16'h8000, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_REM_EVENT, 32'h0, 8'h0, 16'h0, 16'h0, 16'h1234, 8'h0, 5'd0};
    send_word(w);
    w = '{oel_pkg::CMD_SELECTIVE, 32'h0, 8'h0, 16'h0, 16'h0, 16'h0, 8'd200, 5'd31};
    send_word(w);
    w = '{oel_pkg::CMD_SELECTIVE, 32'h0, 8'h0, 16'h0, 16'h0, 16'h0, 8'd3, 5'd0};
    send_word(w);
    w = '{4'd15, 32'h0, 8'h0, 16'h0, 16'h0, 16'h0, 8'h0, 5'd0};
    send_word(w);
    w = '{4'd9, 32'h0, 8'h0, 16'h0, 16'h0, 16'h0, 8'h0, 5'd0};
    send_word(w);
    // Fill past the limit so inserts are dropped.
    for (int i = 0; i < oel_pkg::LIST_DEPTH + 2; i++)
      send_word(random_word(4'($urandom_range(0, 4))));
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off = 150;
    for (int i = 0; i < 40; i++) send_word(random_word(4'($urandom_range(0, 8))));
    drain_results();
  endtask

  task automatic test_random(int n);
    int burst;
    for (int i = 0; i < n; i++) begin
      burst = $urandom_range(0, 99);
      gaps_on = (i / 200) % 2 == 0;
      // Bias inserts versus removals in long runs to sweep the occupancy range.
      if (((i / 60) % 3) == 0) send_word(random_word(4'($urandom_range(0, 4))));
      else if (((i / 60) % 3) == 1) send_word(random_word(4'($urandom_range(5, 8))));
      else send_word(random_word(burst < 3 ? 4'($urandom_range(9, 15)) :
                                             4'($urandom_range(0, 8))));
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(1300);
    $display("Covered %0d command words and %0d results: all insert and removal kinds,",
             words_sent, results_seen);
    $display("full and empty lists, failed matches, unused codes and long output stalls.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
